// ----- design/ilie_pkg.sv -----
// Package for the indexed list insert/erase block: field widths, command,
// status and cell operation codes, and the request/response payload structs.
// No dependencies.
package ilie_pkg;

   localparam int CMD_WIDTH          = 3;
   localparam int INDEX_WIDTH        = 6;
   localparam int VALUE_WIDTH        = 32;
   localparam int COUNT_WIDTH        = 7;
   localparam int STATUS_WIDTH       = 2;
   localparam int DEFAULT_DEPTH      = 64;
   localparam int DEFAULT_DATA_WIDTH = 32;

   // command codes
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_ERASE  = 3'd3,
      CMD_READ   = 3'd4,
      CMD_SHRINK = 3'd5
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // what every cell does this cycle
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_PUSH   = 2'd1,
      OP_INSERT = 2'd2,
      OP_ERASE  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic [INDEX_WIDTH-1:0]  index;
   } cell_ctrl_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]           command;
      logic [INDEX_WIDTH-1:0]         index;
      logic signed [VALUE_WIDTH-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  read_value;
      logic [COUNT_WIDTH-1:0]         count;
      logic [COUNT_WIDTH-1:0]         capacity;
      status_type                     status;
   } rsp_type;

endpackage

// ----- design/ilie_cell.sv -----
// One storage cell of the list row: holds the entry at a fixed position and
// loads from the command, from its lower or its upper neighbor.
// Depends on ilie_pkg.
module ilie_cell #(
   parameter int POS        = 0,
   parameter int CNT_WIDTH  = 7,
   parameter int DATA_WIDTH = 32
) (
   input  logic                        clock,
   input  ilie_pkg::cell_ctrl_type     ctrl,
   input  logic [CNT_WIDTH-1:0]        count,
   input  logic [DATA_WIDTH-1:0]       wr_data,
   input  logic [DATA_WIDTH-1:0]       below_data,
   input  logic [DATA_WIDTH-1:0]       above_data,
   output logic [DATA_WIDTH-1:0]       data,
   output logic [DATA_WIDTH-1:0]       rd_data
);
   import ilie_pkg::*;

   localparam int IW = (CNT_WIDTH > INDEX_WIDTH) ? CNT_WIDTH : INDEX_WIDTH;

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic [IW-1:0]         pos_w;
   logic [IW-1:0]         idx_w;
   logic [IW-1:0]         cnt_w;

   assign pos_w = IW'(POS);
   assign idx_w = IW'(ctrl.index);
   assign cnt_w = IW'(count);

   // next entry value
   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         OP_PUSH: begin
            if (pos_w == cnt_w) data_in = wr_data;
         end
         OP_INSERT: begin
            if (pos_w == idx_w) data_in = wr_data;
            else if (pos_w > idx_w && pos_w <= cnt_w) data_in = below_data;
         end
         OP_ERASE: begin
            if (pos_w >= idx_w && (pos_w + IW'(1)) < cnt_w) data_in = above_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   // gated read: only the addressed cell contributes to the OR select
   assign rd_data = (pos_w == idx_w) ? data_ff : '0;

endmodule

// ----- design/indexed_list_insert_erase_core.sv -----
// Indexed list store top level: command decode, count and capacity
// bookkeeping, the row of ilie_cell entries and the registered result.
// Depends on ilie_pkg and ilie_cell.

// The entries sit in a row of cells that all shift together, so insert and
// erase move every later entry in the same cycle as push, pop, read or
// shrink. The result appears in the output register in the cycle after the
// request transfer, and a new request is taken every cycle as long as that
// register is empty or its result is taken in the same cycle. A read selects
// its entry through an AND-OR gather across the cells. Entries are not
// cleared at reset; only positions below the count are ever read.
module indexed_list_insert_erase_core #(
   parameter int DEPTH      = ilie_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = ilie_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ilie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ilie_pkg::rsp_type rsp_data
);
   import ilie_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;

   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         cap_ff, cap_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  req_fire;

   cell_ctrl_type         ctrl;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
   logic [DATA_WIDTH-1:0] cell_rd [DEPTH];
   logic [DATA_WIDTH-1:0] rd_sel;

   logic [IW-1:0]         idx_w, cnt_w;
   logic                  full, empty;
   logic [CW:0]           cap_dbl;
   logic [CW-1:0]         cap_grow, cap_shrink, cap_fit;
   logic [CW-1:0]         count_dec;
   logic [CW-1:0]         cap_quarter, cap_half;
   status_type            status;
   logic [VALUE_WIDTH-1:0] read_value;

   // handshake: take a request when the output slot is free or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign idx_w   = IW'(req_data.index);
   assign cnt_w   = IW'(count_ff);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_data = DATA_WIDTH'($unsigned(req_data.value));

   // capacity grows to twice (at least one, at most DEPTH) when the count has reached it
   assign cap_dbl = {cap_ff, 1'b0};
   always_comb begin
      cap_grow = cap_ff;
      if (count_ff == cap_ff) begin
         if (cap_dbl == '0) cap_grow = CW'(1);
         else if (cap_dbl > (CW + 1)'(DEPTH)) cap_grow = CW'(DEPTH);
         else cap_grow = cap_dbl[CW-1:0];
      end
   end

   // capacity halves after a removal that leaves a quarter or less
   assign count_dec   = count_ff - CW'(1);
   assign cap_quarter = cap_ff >> 2;
   assign cap_half    = cap_ff >> 1;
   always_comb begin
      cap_shrink = cap_ff;
      if (cap_ff != '0 && count_dec <= cap_quarter) begin
         cap_shrink = (cap_half == '0) ? CW'(1) : cap_half;
      end
   end

   // shrink to fit
   always_comb begin
      cap_fit = cap_ff;
      if (cap_ff > count_ff) cap_fit = (count_ff == '0) ? CW'(1) : count_ff;
   end

   // read gather across the row
   always_comb begin
      rd_sel = '0;
      for (int k = 0; k < DEPTH; k++) begin
         rd_sel = rd_sel | cell_rd[k];
      end
   end

   // command decode
   always_comb begin
      count_in   = count_ff;
      cap_in     = cap_ff;
      status     = ST_OK;
      read_value = '0;
      ctrl.op    = OP_HOLD;
      ctrl.index = req_data.index;
      case (req_data.command)
         CMD_PUSH: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.op  = OP_PUSH;
               cap_in   = cap_grow;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_POP: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               count_in = count_dec;
               cap_in   = cap_shrink;
            end
         end
         CMD_INSERT: begin
            if (idx_w > cnt_w) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.op  = OP_INSERT;
               cap_in   = cap_grow;
               count_in = count_ff + CW'(1);
            end
         end
         CMD_ERASE: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (idx_w >= cnt_w) begin
               status = ST_RANGE;
            end else begin
               ctrl.op  = OP_ERASE;
               count_in = count_dec;
               cap_in   = cap_shrink;
            end
         end
         CMD_READ: begin
            if (idx_w >= cnt_w) status = ST_RANGE;
            else read_value = VALUE_WIDTH'($signed(rd_sel));
         end
         CMD_SHRINK: begin
            cap_in = cap_fit;
         end
         default: begin
            status = ST_OK;
         end
      endcase
      if (!req_fire) ctrl.op = OP_HOLD;
   end

   assign rsp_data_in.read_value = $signed(read_value);
   assign rsp_data_in.count      = COUNT_WIDTH'(count_in);
   assign rsp_data_in.capacity   = COUNT_WIDTH'(cap_in);
   assign rsp_data_in.status     = status;

   // row of cells
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] below_d;
      logic [DATA_WIDTH-1:0] above_d;
      if (k == 0) begin : g_first
         assign below_d = '0;
      end else begin : g_below
         assign below_d = cell_q[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign above_d = '0;
      end else begin : g_above
         assign above_d = cell_q[k+1];
      end
      ilie_cell #(
         .POS        (k),
         .CNT_WIDTH  (CW),
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .wr_data    (wr_data),
         .below_data (below_d),
         .above_data (above_d),
         .data       (cell_q[k]),
         .rd_data    (cell_rd[k])
      );
   end

   // state and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
            cap_ff   <= cap_in;
         end
         if (req_fire) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_cap_bounds: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= cap_ff) && (cap_ff <= CW'(DEPTH)))
      else $error("count above capacity or capacity above depth");

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("transfer without a result");

   a_error_keeps_count: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_data_ff.status == ST_OK || count_ff == $past(count_ff)))
      else $error("failed command changed the count");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for indexed_list_insert_erase_core: random and directed list commands,
// predicted per transfer by a behavioral list model and checked in order against responses.
// Depends on ilie_pkg and the core RTL.
module tb_top;
   import ilie_pkg::*;

   localparam int DEPTH       = DEFAULT_DEPTH;
   localparam int CYCLE_LIMIT = 300000;
   localparam int PRINT_LIMIT = 40;
   localparam int DRAIN_WAIT  = 8;

   // command codes with no operation behind them
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_A = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_B = 3'd7;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // bench state
   req_type pending_req[$];
   rsp_type expected_rsp[$];
   rsp_type step_rsp;
   rsp_type want_rsp;
   int      send_idle_pct = 0;
   int      stall_pct     = 0;
   int      error_count   = 0;
   int      rsp_seen      = 0;
   int      cycle_count   = 0;
   int      gen_count     = 0;
   bit      gen_filling   = 1'b1;

   // list model state
   logic [VALUE_WIDTH-1:0] list_mem [DEPTH];
   int                     list_count = 0;
   int                     list_cap   = 0;

   indexed_list_insert_erase_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // capacity doubles when a growing command finds the list at capacity
   function automatic void grow_cap();
      if (list_count == list_cap) begin
         list_cap = (list_cap * 2 < 1) ? 1 : list_cap * 2;
         if (list_cap > DEPTH) list_cap = DEPTH;
      end
   endfunction

   // capacity halves once a removal leaves a quarter or less in use
   function automatic void shrink_cap();
      if (list_cap > 0 && list_count <= list_cap / 4)
         list_cap = (list_cap / 2 < 1) ? 1 : list_cap / 2;
   endfunction

   // apply one command to the list model and return the response it gives
   task automatic vector_step(input req_type rq, output rsp_type rs);
      int idx;
      int k;
      idx = rq.index;
      rs = '0;
      rs.status = ST_OK;
      case (rq.command)
         CMD_PUSH: begin
            if (list_count >= DEPTH) begin
               rs.status = ST_FULL;
            end else begin
               grow_cap();
               list_mem[list_count] = rq.value;
               list_count++;
            end
         end
         CMD_POP: begin
            if (list_count == 0) begin
               rs.status = ST_EMPTY;
            end else begin
               list_count--;
               shrink_cap();
            end
         end
         CMD_INSERT: begin
            if (idx > list_count) begin
               rs.status = ST_RANGE;
            end else if (list_count >= DEPTH) begin
               rs.status = ST_FULL;
            end else begin
               grow_cap();
               for (k = list_count; k > idx; k--) list_mem[k] = list_mem[k-1];
               list_mem[idx] = rq.value;
               list_count++;
            end
         end
         CMD_ERASE: begin
            if (list_count == 0) begin
               rs.status = ST_EMPTY;
            end else if (idx >= list_count) begin
               rs.status = ST_RANGE;
            end else begin
               for (k = idx; k + 1 < list_count; k++) list_mem[k] = list_mem[k+1];
               list_count--;
               shrink_cap();
            end
         end
         CMD_READ: begin
            if (idx >= list_count) rs.status = ST_RANGE;
            else rs.read_value = list_mem[idx];
         end
         CMD_SHRINK: begin
            if (list_cap > list_count) list_cap = (list_count < 1) ? 1 : list_count;
         end
         default: ;
      endcase
      rs.count    = COUNT_WIDTH'(list_count);
      rs.capacity = COUNT_WIDTH'(list_cap);
   endtask

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // queue one command; track the count the generator expects so indexes stay useful
   task automatic queue_cmd(input logic [CMD_WIDTH-1:0] cmd, input int idx,
                            input logic [VALUE_WIDTH-1:0] val);
      req_type rq;
      rq.command = cmd;
      rq.index   = INDEX_WIDTH'(idx);
      rq.value   = val;
      pending_req = {pending_req, rq};
      case (cmd)
         CMD_PUSH:   if (gen_count < DEPTH) gen_count++;
         CMD_POP:    if (gen_count > 0) gen_count--;
         CMD_INSERT: if (idx <= gen_count && gen_count < DEPTH) gen_count++;
         CMD_ERASE:  if (gen_count > 0 && idx < gen_count) gen_count--;
         default: ;
      endcase
   endtask

   // random commands: long fill and drain runs with legal indexes, plus noise
   task automatic queue_random(input int n);
      int r;
      int idx;
      logic [CMD_WIDTH-1:0] cmd;
      logic [VALUE_WIDTH-1:0] val;
      for (int i = 0; i < n; i++) begin
         if (gen_count == DEPTH && $urandom_range(3) == 0) gen_filling = 1'b0;
         else if (gen_count == 0 && $urandom_range(3) == 0) gen_filling = 1'b1;
         else if ($urandom_range(149) == 0) gen_filling = !gen_filling;
         r = $urandom_range(99);
         if (r < 96) begin
            if (gen_filling) begin
               if (r < 30)      cmd = CMD_PUSH;
               else if (r < 60) cmd = CMD_INSERT;
               else if (r < 74) cmd = CMD_READ;
               else if (r < 82) cmd = CMD_POP;
               else if (r < 90) cmd = CMD_ERASE;
               else             cmd = CMD_SHRINK;
            end else begin
               if (r < 8)       cmd = CMD_PUSH;
               else if (r < 16) cmd = CMD_INSERT;
               else if (r < 30) cmd = CMD_READ;
               else if (r < 58) cmd = CMD_POP;
               else if (r < 88) cmd = CMD_ERASE;
               else             cmd = CMD_SHRINK;
            end
         end else begin
            cmd = CMD_WIDTH'($urandom_range(7));
         end
         // mostly in-range positions, sometimes anywhere in the field
         if ($urandom_range(99) < 15) idx = $urandom_range(63);
         else if (cmd == CMD_INSERT) idx = $urandom_range(gen_count > 63 ? 63 : gen_count);
         else idx = (gen_count == 0) ? 0 : $urandom_range(gen_count - 1);
         case ($urandom_range(19))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'hFFFF_FFFF;
            3:       val = 32'h0000_0000;
            default: val = $urandom();
         endcase
         queue_cmd(cmd, idx, val);
      end
   endtask

   // wait for the queue to empty and every outstanding response to arrive
   task automatic wait_idle();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // driver: present queued commands, predict each one at its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            vector_step(req_data, step_rsp);
            expected_rsp = {expected_rsp, step_rsp};
         end
         if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_req.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: random back-pressure and in-order compare of every response transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               report_error($sformatf("response %0d with no command outstanding", rsp_seen));
            end else begin
               want_rsp = expected_rsp.pop_front();
               if (rsp_data.read_value !== want_rsp.read_value)
                  report_error($sformatf("response %0d read_value: expected %0d got %0d",
                     rsp_seen, want_rsp.read_value, rsp_data.read_value));
               if (rsp_data.count !== want_rsp.count)
                  report_error($sformatf("response %0d count: expected %0d got %0d",
                     rsp_seen, want_rsp.count, rsp_data.count));
               if (rsp_data.capacity !== want_rsp.capacity)
                  report_error($sformatf("response %0d capacity: expected %0d got %0d",
                     rsp_seen, want_rsp.capacity, rsp_data.capacity));
               if (rsp_data.status !== want_rsp.status)
                  report_error($sformatf("response %0d status: expected %0d got %0d",
                     rsp_seen, want_rsp.status, rsp_data.status));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-list errors, extreme values, edges of insert, erase and read
      send_idle_pct = 29;
      stall_pct     = 49;
      queue_cmd(CMD_POP, 0, 32'h0);
      queue_cmd(CMD_ERASE, 0, 32'h0);
      queue_cmd(CMD_READ, 0, 32'h0);
      queue_cmd(CMD_SHRINK, 0, 32'h0);
      queue_cmd(CMD_INSERT, 5, 32'h1111_1111);
      queue_cmd(CMD_INSERT, 0, 32'h7FFF_FFFF);
      queue_cmd(CMD_PUSH, 0, 32'h8000_0000);
      queue_cmd(CMD_PUSH, 63, 32'hFFFF_FFFF);
      queue_cmd(CMD_PUSH, 0, 32'h0000_0000);
      queue_cmd(CMD_INSERT, 4, 32'h1234_5678);
      queue_cmd(CMD_INSERT, 2, 32'h5555_5555);
      queue_cmd(CMD_INSERT, 7, 32'hAAAA_AAAA);
      for (int i = 0; i < 6; i++) queue_cmd(CMD_READ, i, 32'h0);
      queue_cmd(CMD_READ, 63, 32'h0);
      queue_cmd(CMD_ERASE, 63, 32'h0);
      queue_cmd(CMD_ERASE, 5, 32'h0);
      queue_cmd(CMD_ERASE, 0, 32'h0);
      queue_cmd(CMD_POP, 0, 32'h0);
      queue_cmd(CMD_SHRINK, 0, 32'h0);
      queue_cmd(CMD_UNUSED_A, 42, 32'hDEAD_BEEF);
      queue_cmd(CMD_UNUSED_B, 21, 32'hCAFE_F00D);
      queue_cmd(CMD_READ, 1, 32'h0);

      // sender idles often, receiver stalls half the time
      queue_random(510);
      wait_idle();

      // roles swapped; sender waits above until the list core has fully drained
      send_idle_pct = 49;
      stall_pct     = 29;
      queue_random(510);
      wait_idle();

      // full rate both ways
      send_idle_pct = 0;
      stall_pct     = 0;
      queue_random(505);
      wait_idle();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/ilie_pkg.sv
design/ilie_cell.sv
design/indexed_list_insert_erase_core.sv
bench/tb_top.sv
